[rtl/core/vector_range_bearing_elevation_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the range / bearing / elevation converter
// Shared wrappers so every check reports the same way.
// ----------------------------------------------------------------------------
`ifndef VECTOR_RANGE_BEARING_ELEVATION_MACROS_SVH
`define VECTOR_RANGE_BEARING_ELEVATION_MACROS_SVH

// antecedent implies consequent, checked outside reset
`define VRBE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) ante |-> cons) \
		else $error("vrbe check failed");

// condition holds at every edge outside reset
`define VRBE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) cond) \
		else $error("vrbe check failed");

`endif

[rtl/core/vrbe_pkg.sv]
// ----------------------------------------------------------------------------
// vrbe_pkg
// Widths, payload types, CORDIC arctangent table and pipeline latencies.
// ----------------------------------------------------------------------------
package vrbe_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int ANGLE_WIDTH = 16;
	localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
	localparam int DP_WIDTH    = 64;   // internal datapath of the angle units
	localparam int TURN_WIDTH  = 32;   // angle accumulator, one turn = 2^32
	localparam int ITERS       = 32;   // CORDIC micro-rotations
	localparam int HSQRT_OUT   = DP_WIDTH / 2;

	// pipeline depths
	localparam int FRONT_LAT  = 3;                 // input, squares, sums
	localparam int HNORM_LAT  = 5;
	localparam int HSQRT_LAT  = HSQRT_OUT;
	localparam int CORDIC_LAT = 1 + 6 + 1 + ITERS + 1;
	localparam int LATENCY    = FRONT_LAT + HNORM_LAT + HSQRT_LAT + CORDIC_LAT;

	// atan(2^-i) as a fraction of a turn
	localparam logic [TURN_WIDTH-1:0] ATAN_TURNS [ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	localparam logic [TURN_WIDTH-1:0] HALF_TURN = 32'h8000_0000;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] coord_x;
		logic signed [COORD_WIDTH-1:0] coord_y;
		logic signed [COORD_WIDTH-1:0] coord_z;
	} vrbe_in_t;

	typedef struct packed {
		logic [SQ_WIDTH-1:0]           range_squared;
		logic [COORD_WIDTH-1:0]        range;
		logic signed [ANGLE_WIDTH-1:0] bearing;
		logic signed [ANGLE_WIDTH-1:0] elevation;
	} vrbe_out_t;

endpackage

[rtl/core/vrbe_delay.sv]
// ----------------------------------------------------------------------------
// vrbe_delay
// Fixed-length register line that keeps side paths aligned with the pipe.
// ----------------------------------------------------------------------------
module vrbe_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	// shift one tap per clock
	always_ff @(posedge clk) begin
		tap_q[0] <= d;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign q = tap_q[DEPTH-1];

endmodule

[rtl/core/vrbe_isqrt.sv]
// ----------------------------------------------------------------------------
// vrbe_isqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vrbe_isqrt #(
	parameter int IN_W = 48
) (
	input  logic              clk,
	input  logic [IN_W-1:0]   radicand,
	output logic [IN_W/2-1:0] root
);

	localparam int STEPS = IN_W / 2;

	logic [IN_W-1:0] rem_s  [STEPS];
	logic [IN_W-1:0] root_s [STEPS];

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic [IN_W-1:0] BIT = IN_W'(1) << (IN_W - 2 - 2 * i);
		logic [IN_W-1:0] rem_i;
		logic [IN_W-1:0] root_i;
		logic [IN_W-1:0] trial;

		if (i == 0) begin : g_first
			assign rem_i  = radicand;
			assign root_i = '0;
		end else begin : g_next
			assign rem_i  = rem_s[i-1];
			assign root_i = root_s[i-1];
		end

		assign trial = root_i + BIT;

		// try the next bit, keep it if the remainder allows
		always_ff @(posedge clk) begin
			if (rem_i >= trial) begin
				rem_s[i]  <= rem_i - trial;
				root_s[i] <= (root_i >> 1) + BIT;
			end else begin
				rem_s[i]  <= rem_i;
				root_s[i] <= root_i >> 1;
			end
		end
	end

	assign root = root_s[STEPS-1][STEPS-1:0];

endmodule

[rtl/core/vrbe_hnorm.sv]
// ----------------------------------------------------------------------------
// vrbe_hnorm
// Scales x^2+y^2 by the largest 4^k that stays below 2^62, z by 2^k.
// ----------------------------------------------------------------------------
module vrbe_hnorm
	import vrbe_pkg::*;
(
	input  logic                          clk,
	input  logic [SQ_WIDTH-1:0]           horiz,
	input  logic signed [COORD_WIDTH-1:0] z,
	output logic [DP_WIDTH-1:0]           s,
	output logic signed [DP_WIDTH-1:0]    z_scaled
);

	logic [DP_WIDTH-1:0]        s_s  [HNORM_LAT];
	logic signed [DP_WIDTH-1:0] z_s  [HNORM_LAT];
	logic                       nz_s [HNORM_LAT];

	// binary search on k: steps of 16, 8, 4, 2, 1
	for (genvar j = 0; j < HNORM_LAT; j++) begin : g_step
		localparam int A = 16 >> j;
		logic [DP_WIDTH-1:0]        s_i;
		logic signed [DP_WIDTH-1:0] z_i;
		logic                       nz_i;
		logic                       fits;

		if (j == 0) begin : g_first
			assign s_i  = DP_WIDTH'(horiz);
			assign z_i  = DP_WIDTH'(z);
			assign nz_i = (horiz != '0);
		end else begin : g_next
			assign s_i  = s_s[j-1];
			assign z_i  = z_s[j-1];
			assign nz_i = nz_s[j-1];
		end

		// s << 2A still below 2^62; a zero sum is left unscaled
		assign fits = nz_i && (s_i[DP_WIDTH-1 -: 2*A+2] == '0);

		always_ff @(posedge clk) begin
			nz_s[j] <= nz_i;
			if (fits) begin
				s_s[j] <= s_i << (2 * A);
				z_s[j] <= z_i <<< A;
			end else begin
				s_s[j] <= s_i;
				z_s[j] <= z_i;
			end
		end
	end

	assign s        = s_s[HNORM_LAT-1];
	assign z_scaled = z_s[HNORM_LAT-1];

endmodule

[rtl/core/vrbe_cordic.sv]
// ----------------------------------------------------------------------------
// vrbe_cordic
// Pipelined vectoring CORDIC: angle of (a, b) as a rounded binary angle.
// ----------------------------------------------------------------------------
module vrbe_cordic
	import vrbe_pkg::*;
(
	input  logic                          clk,
	input  logic signed [DP_WIDTH-1:0]    a,
	input  logic signed [DP_WIDTH-1:0]    b,
	output logic [ANGLE_WIDTH-1:0]        angle
);

	localparam int NSTEPS = 6;
	localparam logic [TURN_WIDTH-1:0] ROUND_HALF = TURN_WIDTH'(1) << (31 - ANGLE_WIDTH);

	logic signed [DP_WIDTH-1:0] a_s0, b_s0;
	logic [DP_WIDTH-1:0]        m_s0;
	logic [DP_WIDTH-1:0]        abs_a, abs_b;

	logic signed [DP_WIDTH-1:0] na_s [NSTEPS];
	logic signed [DP_WIDTH-1:0] nb_s [NSTEPS];
	logic [DP_WIDTH-1:0]        nm_s [NSTEPS];

	logic signed [DP_WIDTH-1:0] ca_s   [ITERS+1];
	logic signed [DP_WIDTH-1:0] cb_s   [ITERS+1];
	logic [TURN_WIDTH-1:0]      cacc_s [ITERS+1];

	logic [TURN_WIDTH-1:0]      rounded;

	// magnitude estimate: larger of the two absolute values
	assign abs_a = a[DP_WIDTH-1] ? DP_WIDTH'(-a) : DP_WIDTH'(a);
	assign abs_b = b[DP_WIDTH-1] ? DP_WIDTH'(-b) : DP_WIDTH'(b);

	always_ff @(posedge clk) begin
		a_s0 <= a;
		b_s0 <= b;
		m_s0 <= (abs_a > abs_b) ? abs_a : abs_b;
	end

	// normalize so that the magnitude lands in [2^57, 2^58)
	for (genvar j = 0; j < NSTEPS; j++) begin : g_norm
		localparam int L = 32 >> j;
		logic signed [DP_WIDTH-1:0] a_i, b_i;
		logic [DP_WIDTH-1:0]        m_i;
		logic                       sh_l, sh_r;

		if (j == 0) begin : g_first
			assign a_i = a_s0;
			assign b_i = b_s0;
			assign m_i = m_s0;
		end else begin : g_next
			assign a_i = na_s[j-1];
			assign b_i = nb_s[j-1];
			assign m_i = nm_s[j-1];
		end

		assign sh_l = (m_i[DP_WIDTH-1 -: L+6] == '0);
		if (L <= 4) begin : g_right
			assign sh_r = (m_i[DP_WIDTH-1 -: 6] != '0) && (m_i[DP_WIDTH-1 -: 7-L] != '0);
		end else begin : g_left_only
			assign sh_r = 1'b0;
		end

		always_ff @(posedge clk) begin
			if (sh_l) begin
				na_s[j] <= a_i <<< L;
				nb_s[j] <= b_i <<< L;
				nm_s[j] <= m_i << L;
			end else if (sh_r) begin
				na_s[j] <= a_i >>> L;
				nb_s[j] <= b_i >>> L;
				nm_s[j] <= m_i >> L;
			end else begin
				na_s[j] <= a_i;
				nb_s[j] <= b_i;
				nm_s[j] <= m_i;
			end
		end
	end

	// fold the left half plane onto the right one
	always_ff @(posedge clk) begin
		if (na_s[NSTEPS-1] < 0) begin
			ca_s[0]   <= -na_s[NSTEPS-1];
			cb_s[0]   <= -nb_s[NSTEPS-1];
			cacc_s[0] <= HALF_TURN;
		end else begin
			ca_s[0]   <= na_s[NSTEPS-1];
			cb_s[0]   <= nb_s[NSTEPS-1];
			cacc_s[0] <= '0;
		end
	end

	// micro-rotations, one per stage
	for (genvar i = 0; i < ITERS; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (cb_s[i] > 0) begin
				ca_s[i+1]   <= ca_s[i] + (cb_s[i] >>> i);
				cb_s[i+1]   <= cb_s[i] - (ca_s[i] >>> i);
				cacc_s[i+1] <= cacc_s[i] + ATAN_TURNS[i];
			end else begin
				ca_s[i+1]   <= ca_s[i] - (cb_s[i] >>> i);
				cb_s[i+1]   <= cb_s[i] + (ca_s[i] >>> i);
				cacc_s[i+1] <= cacc_s[i] - ATAN_TURNS[i];
			end
		end
	end

	// round to nearest output unit; wraps at a half turn
	assign rounded = cacc_s[ITERS] + ROUND_HALF;

	always_ff @(posedge clk) begin
		angle <= rounded[TURN_WIDTH-1 -: ANGLE_WIDTH];
	end

endmodule

[rtl/core/vector_range_bearing_elevation.sv]
// ----------------------------------------------------------------------------
// vector_range_bearing_elevation
// Cartesian to spherical conversion of a signed 3D vector.
// ----------------------------------------------------------------------------
// Takes one vector per clock whenever start is high; busy is always low.
// Each transaction comes back as a one-cycle done strobe
// with range_squared (exact), range (floor square root), bearing
// (atan2(x, y)) and elevation (atan2(z, horizontal length)). The latency is
// set by the elevation path: square and sum stages, a five-step scaling of
// x^2+y^2, a 32-stage square root of it and a 41-stage CORDIC; all other
// results are delayed to line up with it. The receiver cannot stall the
// block, so results must be captured in the done cycle.
// ----------------------------------------------------------------------------
module vector_range_bearing_elevation
	import vrbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  vrbe_in_t  coord,
	output logic      done,
	output vrbe_out_t result
);

	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic [SQ_WIDTH-1:0]           x2_s2, y2_s2, z2_s2;
	logic signed [COORD_WIDTH-1:0] z_s2;
	logic [SQ_WIDTH-1:0]           horiz_s3, sq_s3;
	logic signed [COORD_WIDTH-1:0] z_s3;
	logic signed [SQ_WIDTH-1:0]    x_sq, y_sq, z_sq;

	logic [LATENCY-1:0]            vld_q;

	logic [DP_WIDTH-1:0]           hs;
	logic signed [DP_WIDTH-1:0]    zsc, zsc_d;
	logic [HSQRT_OUT-1:0]          hroot;
	logic [ANGLE_WIDTH-1:0]        brg, brg_d, elv;
	logic [COORD_WIDTH-1:0]        rng, rng_d;
	logic [SQ_WIDTH-1:0]           rsq_d;
	logic [1:0]                    zero_flags, zero_d;

	assign busy = 1'b0;

	// transaction valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start && !busy};
		end
	end

	assign done = vld_q[LATENCY-1];

	// input, squares, sums
	assign x_sq = x_s1 * x_s1;
	assign y_sq = y_s1 * y_s1;
	assign z_sq = z_s1 * z_s1;

	always_ff @(posedge clk) begin
		x_s1     <= coord.coord_x;
		y_s1     <= coord.coord_y;
		z_s1     <= coord.coord_z;
		x2_s2    <= x_sq;
		y2_s2    <= y_sq;
		z2_s2    <= z_sq;
		z_s2     <= z_s1;
		horiz_s3 <= x2_s2 + y2_s2;
		sq_s3    <= x2_s2 + y2_s2 + z2_s2;
		z_s3     <= z_s2;
	end

	// zero-case flags: {x and y both zero, z zero}
	assign zero_flags = {(x_s1 == '0) && (y_s1 == '0), z_s1 == '0};

	vrbe_delay #(.WIDTH(2), .DEPTH(LATENCY - 1)) u_flag_dly (
		.clk (clk),
		.d   (zero_flags),
		.q   (zero_d)
	);

	// bearing
	vrbe_cordic u_brg_cordic (
		.clk   (clk),
		.a     (DP_WIDTH'(y_s1)),
		.b     (DP_WIDTH'(x_s1)),
		.angle (brg)
	);

	vrbe_delay #(.WIDTH(ANGLE_WIDTH), .DEPTH(LATENCY - 1 - CORDIC_LAT)) u_brg_dly (
		.clk (clk),
		.d   (brg),
		.q   (brg_d)
	);

	// range and squared range
	vrbe_isqrt #(.IN_W(SQ_WIDTH)) u_rng_sqrt (
		.clk      (clk),
		.radicand (sq_s3),
		.root     (rng)
	);

	vrbe_delay #(.WIDTH(COORD_WIDTH), .DEPTH(LATENCY - FRONT_LAT - COORD_WIDTH)) u_rng_dly (
		.clk (clk),
		.d   (rng),
		.q   (rng_d)
	);

	vrbe_delay #(.WIDTH(SQ_WIDTH), .DEPTH(LATENCY - FRONT_LAT)) u_rsq_dly (
		.clk (clk),
		.d   (sq_s3),
		.q   (rsq_d)
	);

	// elevation: scaled horizontal length against scaled z
	vrbe_hnorm u_hnorm (
		.clk      (clk),
		.horiz    (horiz_s3),
		.z        (z_s3),
		.s        (hs),
		.z_scaled (zsc)
	);

	vrbe_isqrt #(.IN_W(DP_WIDTH)) u_hsqrt (
		.clk      (clk),
		.radicand (hs),
		.root     (hroot)
	);

	vrbe_delay #(.WIDTH(DP_WIDTH), .DEPTH(HSQRT_LAT)) u_z_dly (
		.clk (clk),
		.d   (zsc),
		.q   (zsc_d)
	);

	vrbe_cordic u_elv_cordic (
		.clk   (clk),
		.a     ($signed(DP_WIDTH'(hroot))),
		.b     (zsc_d),
		.angle (elv)
	);

	// result assembly
	always_comb begin
		result.range_squared = rsq_d;
		result.range         = rng_d;
		result.bearing       = zero_d[1] ? '0 : brg_d;
		result.elevation     = zero_d[0] ? '0 : elv;
	end

endmodule

[rtl/core/vrbe_checker.sv]
// ----------------------------------------------------------------------------
// vrbe_assert
// Port-level checks of the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "vector_range_bearing_elevation_macros.svh"

module vrbe_assert
	import vrbe_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input vrbe_in_t  coord,
	input logic      done,
	input vrbe_out_t result
);

	// the block always takes a transaction
	`VRBE_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)

	// every accepted transaction returns after the fixed latency
	`VRBE_ASSERT_IMPLY(a_latency, clk, arst_n, start && !busy, ##LATENCY done)

	// no result without a matching transaction
	`VRBE_ASSERT_IMPLY(a_no_spurious, clk, arst_n, done, $past(start && !busy, LATENCY))

	// zero vector gives an all-zero result
	`VRBE_ASSERT_IMPLY(a_zero_vec, clk, arst_n, start && !busy && (coord == '0), ##LATENCY (result == '0))

endmodule

bind vector_range_bearing_elevation vrbe_assert u_vrbe_assert (.*);

[verif/vrbe_checker.sv]
// ----------------------------------------------------------------------------
// vrbe_checker
// Watches the command and result channels of the converter. Predicts
// range_squared, range, bearing and elevation for each accepted transaction
// and compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module vrbe_checker
	import vrbe_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  vrbe_in_t  coord,
	input  logic      done,
	input  vrbe_out_t result,
	output int        errors,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	vrbe_out_t predicted_q[$];

	function automatic longint unsigned mag64(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned rem, root, bitv;
		rem = v;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// CORDIC vectoring: angle of (a, b) as a fraction of a turn, 2^32 per turn
	function automatic logic [31:0] turn_angle(longint a, longint b);
		longint unsigned m;
		longint na, nb;
		logic [31:0] acc;
		m = (mag64(a) > mag64(b)) ? mag64(a) : mag64(b);
		acc = '0;
		while (m < (64'd1 << 57)) begin
			a = a * 2;
			b = b * 2;
			m = m << 1;
		end
		while (m >= (64'd1 << 58)) begin
			a = a >>> 1;
			b = b >>> 1;
			m = m >> 1;
		end
		if (a < 0) begin
			a = -a;
			b = -b;
			acc = HALF_TURN;
		end
		for (int i = 0; i < ITERS; i++) begin
			if (b > 0) begin
				na = a + (b >>> i);
				nb = b - (a >>> i);
				acc = acc + ATAN_TURNS[i];
			end else begin
				na = a - (b >>> i);
				nb = b + (a >>> i);
				acc = acc - ATAN_TURNS[i];
			end
			a = na;
			b = nb;
		end
		return acc;
	endfunction

	function automatic logic [ANGLE_WIDTH-1:0] angle_code(logic [31:0] turns);
		logic [31:0] r;
		r = turns + (32'd1 << (31 - ANGLE_WIDTH));
		return r[31 -: ANGLE_WIDTH];
	endfunction

	function automatic vrbe_out_t predict_spherical(vrbe_in_t v);
		vrbe_out_t o;
		longint x, y, z;
		longint unsigned horiz, sq, s;
		int k;
		x = v.coord_x;
		y = v.coord_y;
		z = v.coord_z;
		horiz = x * x + y * y;
		sq = horiz + z * z;
		o.range_squared = sq[SQ_WIDTH-1:0];
		o.range = COORD_WIDTH'(int_sqrt(sq));
		o.bearing = '0;
		o.elevation = '0;
		if (x != 0 || y != 0) o.bearing = angle_code(turn_angle(y, x));
		if (z != 0) begin
			s = horiz;
			k = 0;
			if (s != 0) begin
				while (s < (64'd1 << 60)) begin
					s = s << 2;
					k++;
				end
			end
			o.elevation = angle_code(turn_angle(longint'(int_sqrt(s)), z <<< k));
		end
		return o;
	endfunction

	// angles may be off by one unit, modulo a turn
	function automatic bit angle_ok(logic [ANGLE_WIDTH-1:0] a, logic [ANGLE_WIDTH-1:0] b);
		logic [ANGLE_WIDTH-1:0] d;
		d = a - b;
		return (d == '0) || (d == 1) || (d == '1);
	endfunction

	assign pending = predicted_q.size();

	// capture commands and compare results
	always @(posedge clk or negedge arst_n) begin
		vrbe_out_t exp_r;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (start && !busy) predicted_q.push_back(predict_spherical(coord));
			if (done) begin
				if (predicted_q.size() == 0) begin
					if (errors < 10) $display("unexpected result %p", result);
					errors <= errors + 1;
				end else begin
					exp_r = predicted_q.pop_front();
					if (result.range_squared !== exp_r.range_squared
						|| result.range !== exp_r.range
						|| !angle_ok(result.bearing, exp_r.bearing)
						|| !angle_ok(result.elevation, exp_r.elevation)
						|| $isunknown(result)) begin
						if (errors < 10)
							$display("mismatch: expected %p actual %p", exp_r, result);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

[verif/tb_vector_range_bearing_elevation.sv]
// ----------------------------------------------------------------------------
// tb_vector_range_bearing_elevation
// Drives directed and random vectors into the converter with and without random gaps;
// the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_vector_range_bearing_elevation
	import vrbe_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = LATENCY + 200;
	localparam logic signed [COORD_WIDTH-1:0] CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	vrbe_in_t  coord;
	logic      done;
	vrbe_out_t result;
	int        errors;
	int        pending;
	int        idle_cycles;
	bit        no_gaps;

	vector_range_bearing_elevation i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.coord(coord), .done(done), .result(result)
	);

	vrbe_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .coord(coord),
		.done(done), .result(result), .errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles without any transaction or result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_vector(logic signed [COORD_WIDTH-1:0] x,
		logic signed [COORD_WIDTH-1:0] y, logic signed [COORD_WIDTH-1:0] z);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		coord <= '{coord_x: x, coord_y: y, coord_z: z};
		do @(posedge clk); while (busy);
	endtask

	function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
		logic [31:0] r;
		int w;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: return r[COORD_WIDTH-1:0];
			1: begin
				w = $urandom_range(1, COORD_WIDTH);
				return COORD_WIDTH'(signed'(r) >>> (32 - w));
			end
			2: return $urandom_range(0, 1) ? CMAX - r[3:0] : CMIN + r[3:0];
			default: return COORD_WIDTH'(int'($urandom_range(0, 6)) - 3);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		coord = '0;
		no_gaps = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: origin, axes, extremes, due south and its rounding
		send_vector(0, 0, 0);
		send_vector(0, 0, 5);
		send_vector(0, 0, CMIN);
		send_vector(0, 0, CMAX);
		send_vector(1, 0, 0);
		send_vector(-1, 0, 0);
		send_vector(0, 1, 0);
		send_vector(0, -1, 0);
		send_vector(0, CMIN, 0);
		send_vector(-1, CMIN, 0);
		send_vector(1, CMIN, 0);
		send_vector(CMAX, CMAX, CMAX);
		send_vector(CMIN, CMIN, CMIN);
		send_vector(CMIN, CMAX, CMIN);
		send_vector(CMAX, CMIN, CMAX);
		send_vector(1, 1, 1);
		send_vector(-1, -1, -1);
		send_vector(3, 4, 12);
		send_vector(1, 0, CMIN);
		send_vector(CMAX, 0, 1);
		send_vector(0, CMAX, -1);

		// hold off until the pipeline drains
		@(negedge clk);
		start <= 1'b0;
		wait (pending == 0);

		// random, in phases with and without gaps
		for (int p = 0; p < 8; p++) begin
			no_gaps = (p % 3 == 1);
			for (int i = 0; i < 200; i++)
				send_vector(rand_coord(), rand_coord(), rand_coord());
		end

		@(negedge clk);
		start <= 1'b0;
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
